// ----- rtl/dynamic_priority_task_picker_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the task picker core
// Each macro checks one property at the rising edge of clk, outside reset.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_PRIORITY_TASK_PICKER_CORE_DEFINES_SVH
`define DYNAMIC_PRIORITY_TASK_PICKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dptp_pkg.sv -----
// ----------------------------------------------------------------------------
// dptp_pkg
// Types and constants shared by the task picker modules.
// ----------------------------------------------------------------------------
package dptp_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int SLOT_W        = 3;
	localparam int TIME_W        = 8;
	localparam int PRIO_W        = 8;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] run_time;
		logic [PRIO_W-1:0] start_prio;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_left;
		logic [PRIO_W-1:0] prio;
	} slot_entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] picked_slot;
		logic              picked_valid;
		logic [TIME_W-1:0] time_left;
		logic [PRIO_W-1:0] new_prio;
		logic              finished;
		logic              all_done;
	} result_t;

endpackage

// ----- rtl/dptp_slot_mem.sv -----
// ----------------------------------------------------------------------------
// dptp_slot_mem
// Slot table: priority and remaining time in a memory with registered read,
// ready marks in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module dptp_slot_mem #(
	parameter int NUM_SLOTS = dptp_pkg::NUM_SLOTS_DEF,
	localparam int AW = $clog2(NUM_SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [AW-1:0]         rd_addr,
	output dptp_pkg::slot_entry_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  dptp_pkg::slot_entry_t wr_data,
	input  logic                  wr_ready,
	output logic [NUM_SLOTS-1:0]  ready
);
	import dptp_pkg::*;

	slot_entry_t          mem [NUM_SLOTS];
	slot_entry_t          rd_data_q;
	logic [NUM_SLOTS-1:0] ready_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Entries that are not ready are never picked, so the memory itself needs no clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= '0;
		end else if (wr_en) begin
			ready_q[wr_addr] <= wr_ready;
		end
	end

	assign rd_data = rd_data_q;
	assign ready   = ready_q;

endmodule

// ----- rtl/dptp_seq.sv -----
// ----------------------------------------------------------------------------
// dptp_seq
// Sequencer with one shared priority comparator: on a tick it walks the slot table
// one entry a cycle, keeps the best ready slot, then writes it back; a load writes one slot.
// ----------------------------------------------------------------------------
module dptp_seq #(
	parameter int NUM_SLOTS = dptp_pkg::NUM_SLOTS_DEF,
	localparam int AW = $clog2(NUM_SLOTS),
	localparam int CW = $clog2(NUM_SLOTS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  dptp_pkg::item_t       item,
	output logic [AW-1:0]         rd_addr,
	input  dptp_pkg::slot_entry_t rd_data,
	input  logic [NUM_SLOTS-1:0]  ready,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output dptp_pkg::slot_entry_t wr_data,
	output logic                  wr_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output dptp_pkg::result_t     res
);
	import dptp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_WB   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [CW-1:0] K_LAST = CW'(NUM_SLOTS);

	logic [2:0]    state_q;
	logic [CW-1:0] k_q;
	logic          cmp_valid_q;
	logic          found_q;
	item_t         item_q;
	logic [AW-1:0] cmp_idx_q;
	logic [AW-1:0] best_idx_q;
	slot_entry_t   best_q;
	result_t       res_q;

	logic          accept;
	logic          load_in_range;
	logic [31:0]   slot_ext;
	logic [AW-1:0] load_addr;
	logic [31:0]   best_ext;
	logic          take;
	slot_entry_t   tick_entry;
	result_t       res_d;

	assign accept        = item_valid && item_ready;
	assign item_ready    = (state_q == ST_IDLE);
	assign slot_ext      = 32'(item_q.slot);
	assign load_addr     = slot_ext[AW-1:0];
	assign load_in_range = (slot_ext < 32'(NUM_SLOTS));
	assign best_ext      = 32'(best_idx_q);
	assign rd_addr       = k_q[AW-1:0];

	// The shared comparator: the entry read last cycle against the best so far.
	// A strict compare keeps the lowest index on equal priorities.
	assign take = cmp_valid_q && ready[cmp_idx_q] && (!found_q || (rd_data.prio > best_q.prio));

	always_comb begin
		tick_entry.time_left = (best_q.time_left != '0) ? best_q.time_left - TIME_W'(1) : '0;
		tick_entry.prio      = (best_q.prio != '0) ? best_q.prio - PRIO_W'(1) : '0;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = tick_entry;
		if (state_q == ST_LOAD) begin
			wr_en           = load_in_range;
			wr_addr         = load_addr;
			wr_data.time_left = item_q.run_time;
			wr_data.prio    = item_q.start_prio;
		end else if (state_q == ST_WB) begin
			wr_en = found_q;
		end
		wr_ready = (wr_data.time_left != '0);
	end

	always_comb begin
		res_d = '0;
		if (state_q == ST_LOAD) begin
			if (load_in_range) begin
				res_d.picked_slot  = item_q.slot;
				res_d.picked_valid = 1'b1;
				res_d.time_left    = item_q.run_time;
				res_d.new_prio     = item_q.start_prio;
			end
		end else if (found_q) begin
			res_d.picked_slot  = best_ext[SLOT_W-1:0];
			res_d.picked_valid = 1'b1;
			res_d.time_left    = tick_entry.time_left;
			res_d.new_prio     = tick_entry.prio;
			res_d.finished     = (tick_entry.time_left == '0);
		end
	end

	always_comb begin
		res          = res_q;
		res.all_done = ~|ready;
	end
	assign res_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			cmp_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			cmp_valid_q <= (state_q == ST_SCAN) && (k_q != K_LAST);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						found_q <= 1'b0;
						state_q <= (item.action == ACT_TICK) ? ST_SCAN : ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (k_q == K_LAST) begin
						state_q <= ST_WB;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				ST_WB: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		cmp_idx_q <= k_q[AW-1:0];
		if (state_q == ST_SCAN && take) begin
			best_idx_q <= cmp_idx_q;
			best_q     <= rd_data;
		end
		if (state_q == ST_LOAD || state_q == ST_WB) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/dynamic_priority_task_picker_core.sv -----
// ----------------------------------------------------------------------------
// dynamic_priority_task_picker_core
// Priority task picker: loads task slots and, on each tick, runs the ready
// slot with the highest priority for one time unit.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                      Contents
// s        in   s_tvalid s_tready s_tdata    one load or tick request
//                s_tuser                      action (0 load, 1 tick)
// m        out  m_tvalid m_tready m_tdata    one result per request
//
// A tick scans every slot: the single comparator reads one slot from the
// table memory per cycle. A load writes its slot directly, without a scan.
// One request is worked on at a time.
// Reset clears all ready marks at once; no clearing pass is needed.
// A stalled result waits in the output register while the next request runs.
//
module dynamic_priority_task_picker_core #(
	parameter int NUM_SLOTS = dptp_pkg::NUM_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // slot[2:0], run_time[10:3], start_priority[18:11], zeros
	input  logic        s_tuser,   // action[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // picked_slot[2:0], picked_valid[3], time_left[11:4],
	                               // new_priority[19:12], finished[20], all_done[21], zeros
);
	import dptp_pkg::*;

	localparam int AW = $clog2(NUM_SLOTS);

	item_t                item;
	logic [AW-1:0]        rd_addr;
	slot_entry_t          rd_data;
	logic [NUM_SLOTS-1:0] ready;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	slot_entry_t          wr_data;
	logic                 wr_ready;
	logic                 res_valid;
	logic                 res_ready;
	result_t              res;
	logic                 m_valid_q;
	result_t              m_data_q;

	assign item.action     = s_tuser;
	assign item.slot       = s_tdata[2:0];
	assign item.run_time   = s_tdata[10:3];
	assign item.start_prio = s_tdata[18:11];

	dptp_slot_mem #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.wr_ready(wr_ready),
		.ready   (ready)
	);

	dptp_seq #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item      (item),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.ready     (ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.wr_ready  (wr_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_data_q.all_done, m_data_q.finished, m_data_q.new_prio,
		m_data_q.time_left, m_data_q.picked_valid, m_data_q.picked_slot};

`include "dynamic_priority_task_picker_core_defines.svh"

	// Every request keeps the block busy for at least the following cycle.
	`DPTP_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "ready right after a request")
	// A slot that reached zero run time is reported with zero time left.
	`DPTP_ASSERT_NOW(a_finish_zero, m_tvalid && m_tdata[20], m_tdata[3] && m_tdata[11:4] == 8'd0, "finished with time left")
	// A reported slot with time left stays ready, so the table cannot be all done.
	`DPTP_ASSERT_NOW(a_ready_kept, m_tvalid && m_tdata[3] && m_tdata[11:4] != 8'd0, !m_tdata[21], "all done with a live slot")

endmodule
